// File: rtl/svpwm_pkg.sv
// Shared constants and helpers for the SVPWM timing generator.
// No dependencies.
package svpwm_pkg;

	// Default timer count width
	localparam int COUNT_WIDTH_DEF = 16;

	// sqrt(3)/2 in unsigned Q16
	localparam logic [16:0] SQRT3_HALF_Q16 = 17'd56756;

	// Configuration register indexes
	localparam logic [2:0] REG_PWM_PERIOD   = 3'd0;
	localparam logic [2:0] REG_VOLTAGE_GAIN = 3'd1;
	localparam logic [2:0] REG_SAMPLE_LEAD  = 3'd2;
	localparam logic [2:0] REG_NOISE_TIME   = 3'd3;
	localparam logic [2:0] REG_DEAD_TIME    = 3'd4;

	// Sector numbers
	localparam logic [2:0] SECTOR_ZERO = 3'd0;

	// Modulation zone codes
	localparam logic [1:0] ZONE_LOW  = 2'd0;
	localparam logic [1:0] ZONE_MID  = 2'd1;
	localparam logic [1:0] ZONE_HIGH = 2'd2;

	// Sign code 4C+2B+A to sector number
	function automatic logic [2:0] sector_of_code(input logic [2:0] code);
		logic [2:0] s;
		unique case (code)
			3'd1: s = 3'd2;
			3'd2: s = 3'd6;
			3'd3: s = 3'd1;
			3'd4: s = 3'd4;
			3'd5: s = 3'd3;
			3'd6: s = 3'd5;
			default: s = SECTOR_ZERO;
		endcase
		return s;
	endfunction

endpackage

// File: rtl/svpwm_timing_generator_core.sv
// Seven-segment SVPWM timing generator: sector, compare values, zone, ADC trigger.
// Depends on svpwm_pkg.
// Throughput one beat per cycle while the result is not held back by out_ready.
// The depth is set by the 16-stage restoring divider that scales active times when
// they overrun the period (one quotient bit per stage, two dividers side by side).
// The whole pipe advances together and holds when the result waits on out_ready.
// Reset (arst_n low, asynchronous) empties the pipe and loads register defaults.
module svpwm_timing_generator_core
	import svpwm_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [31:0]        wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] alpha_voltage,
	input  logic signed [15:0] beta_voltage,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         sector,
	output logic [15:0]        compare_a,
	output logic [15:0]        compare_b,
	output logic [15:0]        compare_c,
	output logic               overmodulated,
	output logic [1:0]         modulation_zone,
	output logic [15:0]        sample_point
);

	localparam int DIV_STAGES = 16;
	localparam logic [15:0] CMASK = (COUNT_WIDTH >= 16) ? 16'hFFFF :
		16'((33'd1 << COUNT_WIDTH) - 33'd1);
	localparam logic [33:0] CMAX = (34'd1 << COUNT_WIDTH) - 34'd1;

	// Side data carried through the divider
	typedef struct packed {
		logic [2:0]  sec;
		logic        over;
		logic [43:0] sum;
		logic [15:0] ne0;
		logic [15:0] ne1;
		logic [15:0] ne2;
	} side_t;

	// Configuration registers
	logic [15:0] period_q;
	logic [31:0] gain_q;
	logic [15:0] lead_q;
	logic [15:0] noise_q;
	logic [15:0] dead_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= 16'd4000;
			gain_q   <= '0;
			lead_q   <= '0;
			noise_q  <= '0;
			dead_q   <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_PWM_PERIOD:   period_q <= wr_data[15:0];
				REG_VOLTAGE_GAIN: gain_q   <= wr_data;
				REG_SAMPLE_LEAD:  lead_q   <= wr_data[15:0];
				REG_NOISE_TIME:   noise_q  <= wr_data[15:0];
				REG_DEAD_TIME:    dead_q   <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	// Whole pipe moves when the result slot is free or being taken
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// Stage 1: projection products
	logic               v_s1;
	logic signed [32:0] p2_s1;
	logic signed [27:0] u1_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			p2_s1 <= 33'(alpha_voltage * $signed({1'b0, SQRT3_HALF_Q16}))
				- 33'(beta_voltage * $signed(17'sd32768));
			u1_s1 <= 28'(beta_voltage) <<< 8;
		end
	end

	// Stage 2: sign code, sector, select projections
	logic signed [27:0] u2_c, u3_c, sa_c, sb_c;
	logic [2:0]  code_c;
	logic [26:0] ma_c, mb_c;

	always_comb begin
		u2_c   = 28'(p2_s1 >>> 8);
		u3_c   = -u2_c - u1_s1;
		code_c = {u3_c > 0, u2_c > 0, u1_s1 > 0};
		case (code_c)
			3'd1: begin sa_c = -u3_c;  sb_c = -u2_c;  end
			3'd2: begin sa_c = -u1_s1; sb_c = -u3_c;  end
			3'd3: begin sa_c = u1_s1;  sb_c = u2_c;   end
			3'd4: begin sa_c = -u2_c;  sb_c = -u1_s1; end
			3'd5: begin sa_c = u3_c;   sb_c = u1_s1;  end
			3'd6: begin sa_c = u2_c;   sb_c = u3_c;   end
			default: begin sa_c = '0; sb_c = '0; end
		endcase
		ma_c = (sa_c > 0) ? sa_c[26:0] : '0;
		mb_c = (sb_c > 0) ? sb_c[26:0] : '0;
	end

	logic        v_s2;
	logic [2:0]  sec_s2;
	logic [26:0] ma_s2, mb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sec_s2 <= sector_of_code(code_c);
			ma_s2  <= ma_c;
			mb_s2  <= mb_c;
		end
	end

	// Stage 3: active times in Q.16 counts
	logic        v_s3;
	logic [2:0]  sec_s3;
	logic [42:0] ta_s3, tb_s3;
	logic [58:0] pa_c, pb_c;

	assign pa_c = 59'(gain_q) * 59'(ma_s2);
	assign pb_c = 59'(gain_q) * 59'(mb_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sec_s3 <= sec_s2;
			ta_s3  <= pa_c[58:16];
			tb_s3  <= pb_c[58:16];
		end
	end

	// Stage 4: overrun test, normal edges, dividends
	logic [43:0] sum_c;
	logic [44:0] perq_c, t0_c, e1w_c, e2w_c;

	always_comb begin
		sum_c  = 44'(ta_s3) + 44'(tb_s3);
		perq_c = {13'd0, period_q, 16'd0};
		t0_c   = (perq_c - 45'(sum_c)) >> 1;
		e1w_c  = t0_c + 45'(ta_s3);
		e2w_c  = t0_c + 45'(sum_c);
	end

	logic        v_s4;
	side_t       side_s4;
	logic [59:0] na_s4, nb_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			side_s4.sec  <= sec_s3;
			side_s4.over <= 45'(sum_c) > perq_c;
			side_s4.sum  <= sum_c;
			side_s4.ne0  <= t0_c[31:16];
			side_s4.ne1  <= e1w_c[31:16];
			side_s4.ne2  <= e2w_c[31:16];
			na_s4        <= 60'(ta_s3) * 60'(period_q);
			nb_s4        <= 60'(tb_s3) * 60'(period_q);
		end
	end

	// Stages 5..20: restoring dividers, one quotient bit per stage, MSB first
	logic        div_v_s5  [0:DIV_STAGES-1];
	side_t       div_sd_s5 [0:DIV_STAGES-1];
	logic [59:0] div_ra_s5 [0:DIV_STAGES-1];
	logic [59:0] div_rb_s5 [0:DIV_STAGES-1];
	logic [15:0] div_qa_s5 [0:DIV_STAGES-1];
	logic [15:0] div_qb_s5 [0:DIV_STAGES-1];

	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
		logic        vin;
		side_t       sin;
		logic [59:0] rain, rbin, dv;
		logic [15:0] qain, qbin;

		if (j == 0) begin : g_first
			assign vin  = v_s4;
			assign sin  = side_s4;
			assign rain = na_s4;
			assign rbin = nb_s4;
			assign qain = '0;
			assign qbin = '0;
		end else begin : g_next
			assign vin  = div_v_s5[j-1];
			assign sin  = div_sd_s5[j-1];
			assign rain = div_ra_s5[j-1];
			assign rbin = div_rb_s5[j-1];
			assign qain = div_qa_s5[j-1];
			assign qbin = div_qb_s5[j-1];
		end

		assign dv = 60'(sin.sum) << (DIV_STAGES - 1 - j);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) div_v_s5[j] <= 1'b0;
			else if (en) div_v_s5[j] <= vin;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				div_sd_s5[j] <= sin;
				if (rain >= dv) begin
					div_ra_s5[j] <= rain - dv;
					div_qa_s5[j] <= qain | (16'd1 << (DIV_STAGES - 1 - j));
				end else begin
					div_ra_s5[j] <= rain;
					div_qa_s5[j] <= qain;
				end
				if (rbin >= dv) begin
					div_rb_s5[j] <= rbin - dv;
					div_qb_s5[j] <= qbin | (16'd1 << (DIV_STAGES - 1 - j));
				end else begin
					div_rb_s5[j] <= rbin;
					div_qb_s5[j] <= qbin;
				end
			end
		end
	end

	// Stage 21: edges, phase compares, reference phase
	side_t       sd_l;
	logic [15:0] e0_c, e1_c, e2_c, ca_c, cb_c, cc_c, ref_c;

	assign sd_l = div_sd_s5[DIV_STAGES-1];

	always_comb begin
		if (sd_l.over) begin
			e0_c = '0;
			e1_c = div_qa_s5[DIV_STAGES-1];
			e2_c = div_qa_s5[DIV_STAGES-1] + div_qb_s5[DIV_STAGES-1];
		end else begin
			e0_c = sd_l.ne0;
			e1_c = sd_l.ne1;
			e2_c = sd_l.ne2;
		end
		unique case (sd_l.sec)
			3'd1: begin ca_c = e2_c; cb_c = e1_c; cc_c = e0_c; end
			3'd2: begin ca_c = e1_c; cb_c = e2_c; cc_c = e0_c; end
			3'd3: begin ca_c = e0_c; cb_c = e2_c; cc_c = e1_c; end
			3'd4: begin ca_c = e0_c; cb_c = e1_c; cc_c = e2_c; end
			3'd5: begin ca_c = e1_c; cb_c = e0_c; cc_c = e2_c; end
			3'd6: begin ca_c = e2_c; cb_c = e0_c; cc_c = e1_c; end
			default: begin ca_c = e0_c; cb_c = e0_c; cc_c = e0_c; end
		endcase
		ca_c = ca_c & CMASK;
		cb_c = cb_c & CMASK;
		cc_c = cc_c & CMASK;
		case (sd_l.sec)
			3'd1, 3'd6: ref_c = ca_c;
			3'd2, 3'd3: ref_c = cb_c;
			3'd4, 3'd5: ref_c = cc_c;
			default:    ref_c = period_q >> 1;
		endcase
	end

	logic        v_s21;
	logic [2:0]  sec_s21;
	logic        over_s21;
	logic [15:0] ca_s21, cb_s21, cc_s21, ref_s21;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s21 <= 1'b0;
		else if (en) v_s21 <= div_v_s5[DIV_STAGES-1];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sec_s21  <= sd_l.sec;
			over_s21 <= sd_l.over;
			ca_s21   <= ca_c;
			cb_s21   <= cb_c;
			cc_s21   <= cc_c;
			ref_s21  <= ref_c;
		end
	end

	// Stage 22: zone and ADC trigger point, clamped to the count range
	logic [16:0] tdtn_c, ref2_c;
	logic [17:0] tall_c;
	logic [1:0]  zone_c;
	logic [33:0] sp_c, spc_c;

	always_comb begin
		tdtn_c = 17'(dead_q) + 17'(noise_q);
		tall_c = 18'(tdtn_c) + 18'(lead_q);
		ref2_c = {ref_s21, 1'b0};
		if (17'(ref_s21) > tdtn_c) begin
			zone_c = ZONE_LOW;
			sp_c   = (ref_s21 > lead_q) ? 34'(ref_s21 - lead_q) : '0;
		end else if (tall_c > 18'(ref2_c)) begin
			zone_c = ZONE_HIGH;
			if (17'(ref_s21) >= tdtn_c) sp_c = 34'(17'(ref_s21) - tdtn_c);
			else if (period_q != '0) sp_c = 34'(period_q - 16'd1);
			else sp_c = '0;
		end else begin
			zone_c = ZONE_MID;
			sp_c   = 34'(ref_s21) + 34'(lead_q);
		end
		spc_c = (sp_c > CMAX) ? CMAX : sp_c;
	end

	logic        v_s22;
	logic [2:0]  sec_s22;
	logic        over_s22;
	logic [1:0]  zone_s22;
	logic [15:0] ca_s22, cb_s22, cc_s22, sp_s22;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s22 <= 1'b0;
		else if (en) v_s22 <= v_s21;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sec_s22  <= sec_s21;
			over_s22 <= over_s21;
			zone_s22 <= zone_c;
			ca_s22   <= ca_s21;
			cb_s22   <= cb_s21;
			cc_s22   <= cc_s21;
			sp_s22   <= spc_c[15:0];
		end
	end

	assign out_valid       = v_s22;
	assign sector          = sec_s22;
	assign compare_a       = ca_s22;
	assign compare_b       = cb_s22;
	assign compare_c       = cc_s22;
	assign overmodulated   = over_s22;
	assign modulation_zone = zone_s22;
	assign sample_point    = sp_s22;

	// Checks
	a_stall_only_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled while result slot free");

	a_zero_vector_not_over: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && sector == SECTOR_ZERO) |-> !overmodulated)
		else $error("zero vector flagged as overmodulated");

	a_zero_vector_centred: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && sector == SECTOR_ZERO) |->
		(compare_a == compare_b && compare_b == compare_c))
		else $error("zero vector compares differ");

	a_zone_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (modulation_zone == ZONE_LOW || modulation_zone == ZONE_MID ||
		modulation_zone == ZONE_HIGH))
		else $error("bad modulation zone");

endmodule
